// ----- design/gblur_pkg.sv -----
// Shared types and constants for the 3x3 smoothing filter block.
`default_nettype none

package gblur_pkg;

    localparam int PIX_W   = 8;
    localparam int COORD_W = 10;
    localparam int COEF_W  = 16;
    localparam int KROW_W  = 3 * COEF_W;
    localparam int CFG_IDX_W = 2;
    localparam int PROD_W  = PIX_W + COEF_W;
    localparam int ACC_W   = 28;
    localparam int FRAC_W  = 16;

    typedef logic [3:0] tap_t;

    localparam tap_t TAP_FIRST  = 4'd0;
    localparam tap_t TAP_CENTER = 4'd4;
    localparam tap_t TAP_LAST   = 4'd8;
    localparam tap_t TAP_DRAIN  = 4'd9;

    localparam logic [CFG_IDX_W-1:0] REG_KROW_TOP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KROW_MIDDLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KROW_BOTTOM = 2'd2;

    localparam logic [KROW_W-1:0] KROW_TOP_RST    = 48'h1000_2000_1000;
    localparam logic [KROW_W-1:0] KROW_MIDDLE_RST = 48'h2000_4000_2000;
    localparam logic [KROW_W-1:0] KROW_BOTTOM_RST = 48'h1000_2000_1000;

    localparam logic [ACC_W:0] ROUND_HALF = 29'h0000_8000;

    typedef enum logic [1:0] {
        OUT_ZERO,
        OUT_PASS,
        OUT_FILT
    } out_sel_t;

    typedef struct packed {
        logic     latch;
        logic     addr_en;
        tap_t     addr_tap;
        logic     rd_en;
        logic     wr_en;
        logic     acc_clr;
        logic     mac_en;
        tap_t     mac_tap;
        logic     out_en;
        out_sel_t out_sel;
    } cmd_t;

    typedef struct packed {
        logic in_range;
        logic border;
        logic is_load;
    } status_t;

endpackage

`default_nettype wire

// ----- design/gblur_dp.sv -----
// Datapath: frame memory, coordinate latch, kernel registers, address unit and MAC.
`default_nettype none

module gblur_dp #(
    parameter int WIDTH  = 800,
    parameter int HEIGHT = 600
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 mode,
    input  wire logic [gblur_pkg::COORD_W-1:0]        col,
    input  wire logic [gblur_pkg::COORD_W-1:0]        row,
    input  wire logic [gblur_pkg::PIX_W-1:0]          pixel_in,
    input  wire logic                                 cfg_wr,
    input  wire logic [gblur_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [gblur_pkg::KROW_W-1:0]         cfg_data,
    input  wire gblur_pkg::cmd_t                      cmd,
    output gblur_pkg::status_t                        status,
    output logic [gblur_pkg::PIX_W-1:0]               pixel_out,
    output logic                                      saturated
);

    localparam int DEPTH  = WIDTH * HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int RC_W   = gblur_pkg::COORD_W + 1;
    localparam int RND_W  = gblur_pkg::ACC_W + 1 - gblur_pkg::FRAC_W;

    logic                             mode_reg;
    logic [gblur_pkg::COORD_W-1:0]    col_reg;
    logic [gblur_pkg::COORD_W-1:0]    row_reg;
    logic [gblur_pkg::PIX_W-1:0]      pix_reg;

    logic [gblur_pkg::KROW_W-1:0]     krow_top_reg;
    logic [gblur_pkg::KROW_W-1:0]     krow_mid_reg;
    logic [gblur_pkg::KROW_W-1:0]     krow_bot_reg;

    logic [ADDR_W-1:0]                addr_reg;
    logic [ADDR_W-1:0]                addr_next;
    logic [RC_W-1:0]                  r_tap;
    logic [RC_W-1:0]                  c_tap;

    logic [gblur_pkg::PIX_W-1:0]      frame_mem [DEPTH];
    logic [gblur_pkg::PIX_W-1:0]      rdata_reg;

    logic [gblur_pkg::COEF_W-1:0]     coef_sel;
    logic [gblur_pkg::PROD_W-1:0]     prod;
    logic [gblur_pkg::ACC_W-1:0]      acc_reg;
    logic [gblur_pkg::ACC_W-1:0]      acc_next;
    logic [gblur_pkg::ACC_W:0]        rnd_sum;
    logic [RND_W-1:0]                 rounded;
    logic                             filt_sat;

    logic [gblur_pkg::PIX_W-1:0]      pixel_out_reg;
    logic [gblur_pkg::PIX_W-1:0]      pixel_out_next;
    logic                             sat_reg;
    logic                             sat_next;

    function automatic logic [1:0] tap_row(input gblur_pkg::tap_t t);
        logic [1:0] r;
        case (t)
            4'd0, 4'd1, 4'd2: r = 2'd0;
            4'd3, 4'd4, 4'd5: r = 2'd1;
            4'd6, 4'd7, 4'd8: r = 2'd2;
            default:          r = 2'd1;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] tap_col(input gblur_pkg::tap_t t);
        logic [1:0] c;
        case (t)
            4'd0, 4'd3, 4'd6: c = 2'd0;
            4'd1, 4'd4, 4'd7: c = 2'd1;
            4'd2, 4'd5, 4'd8: c = 2'd2;
            default:          c = 2'd1;
        endcase
        return c;
    endfunction

    // Hold the coordinates and pixel of the accepted item.
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            mode_reg <= mode;
            col_reg  <= col;
            row_reg  <= row;
            pix_reg  <= pixel_in;
        end
    end

    always_comb
    begin
        status.in_range = (32'(col_reg) < 32'(WIDTH)) && (32'(row_reg) < 32'(HEIGHT));
        status.border   = (col_reg == '0) || (row_reg == '0) ||
                          (32'(col_reg) >= 32'(WIDTH - 1)) ||
                          (32'(row_reg) >= 32'(HEIGHT - 1));
        status.is_load  = !mode_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            krow_top_reg <= gblur_pkg::KROW_TOP_RST;
            krow_mid_reg <= gblur_pkg::KROW_MIDDLE_RST;
            krow_bot_reg <= gblur_pkg::KROW_BOTTOM_RST;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                gblur_pkg::REG_KROW_TOP:    krow_top_reg <= cfg_data;
                gblur_pkg::REG_KROW_MIDDLE: krow_mid_reg <= cfg_data;
                gblur_pkg::REG_KROW_BOTTOM: krow_bot_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Neighbor address: (row + dr) * WIDTH + (col + dc), dr and dc in -1..1.
    always_comb
    begin
        r_tap     = RC_W'(row_reg) + RC_W'(tap_row(cmd.addr_tap)) - RC_W'(1);
        c_tap     = RC_W'(col_reg) + RC_W'(tap_col(cmd.addr_tap)) - RC_W'(1);
        addr_next = ADDR_W'(32'(r_tap) * 32'(WIDTH) + 32'(c_tap));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.addr_en)
        begin
            addr_reg <= addr_next;
        end
    end

    // Single-port frame memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            frame_mem[addr_reg] <= pix_reg;
        end
        else if (cmd.rd_en)
        begin
            rdata_reg <= frame_mem[addr_reg];
        end
    end

    always_comb
    begin
        case (cmd.mac_tap)
            4'd0:    coef_sel = krow_top_reg[15:0];
            4'd1:    coef_sel = krow_top_reg[31:16];
            4'd2:    coef_sel = krow_top_reg[47:32];
            4'd3:    coef_sel = krow_mid_reg[15:0];
            4'd4:    coef_sel = krow_mid_reg[31:16];
            4'd5:    coef_sel = krow_mid_reg[47:32];
            4'd6:    coef_sel = krow_bot_reg[15:0];
            4'd7:    coef_sel = krow_bot_reg[31:16];
            4'd8:    coef_sel = krow_bot_reg[47:32];
            default: coef_sel = '0;
        endcase
        prod = gblur_pkg::PROD_W'(rdata_reg) * gblur_pkg::PROD_W'(coef_sel);
        acc_next = acc_reg + gblur_pkg::ACC_W'(prod);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (cmd.mac_en)
        begin
            acc_reg <= acc_next;
        end
    end

    // Round half up, then clamp to the pixel range.
    always_comb
    begin
        rnd_sum  = (gblur_pkg::ACC_W + 1)'(acc_reg) + gblur_pkg::ROUND_HALF;
        rounded  = rnd_sum[gblur_pkg::ACC_W:gblur_pkg::FRAC_W];
        filt_sat = |rounded[RND_W-1:gblur_pkg::PIX_W];

        case (cmd.out_sel)
            gblur_pkg::OUT_PASS:
            begin
                pixel_out_next = rdata_reg;
                sat_next       = 1'b0;
            end
            gblur_pkg::OUT_FILT:
            begin
                pixel_out_next = filt_sat ? '1 : rounded[gblur_pkg::PIX_W-1:0];
                sat_next       = filt_sat;
            end
            default:
            begin
                pixel_out_next = '0;
                sat_next       = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_en)
        begin
            pixel_out_reg <= pixel_out_next;
            sat_reg       <= sat_next;
        end
    end

    assign pixel_out = pixel_out_reg;
    assign saturated = sat_reg;

endmodule

`default_nettype wire

// ----- design/gblur_ctrl.sv -----
// Controller: sequences load, pass-through and nine-tap filter transfers.
`default_nettype none

module gblur_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire gblur_pkg::status_t   status,
    output gblur_pkg::cmd_t           cmd,
    output logic                      busy,
    output logic                      done
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_WRITE,
        S_READ,
        S_PASS,
        S_TAPS,
        S_FIN
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    gblur_pkg::tap_t  step_reg;
    gblur_pkg::tap_t  step_next;
    logic             done_reg;
    logic             done_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        step_next  = step_reg;
        done_next  = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                cmd.latch = start;
                if (start)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!status.in_range)
                begin
                    cmd.out_en  = 1'b1;
                    cmd.out_sel = gblur_pkg::OUT_ZERO;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (status.is_load)
                begin
                    cmd.addr_en  = 1'b1;
                    cmd.addr_tap = gblur_pkg::TAP_CENTER;
                    state_next   = S_WRITE;
                end
                else if (status.border)
                begin
                    cmd.addr_en  = 1'b1;
                    cmd.addr_tap = gblur_pkg::TAP_CENTER;
                    state_next   = S_READ;
                end
                else
                begin
                    cmd.acc_clr  = 1'b1;
                    cmd.addr_en  = 1'b1;
                    cmd.addr_tap = gblur_pkg::TAP_FIRST;
                    step_next    = gblur_pkg::TAP_FIRST;
                    state_next   = S_TAPS;
                end
            end
            S_WRITE:
            begin
                cmd.wr_en   = 1'b1;
                cmd.out_en  = 1'b1;
                cmd.out_sel = gblur_pkg::OUT_ZERO;
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end
            S_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_PASS;
            end
            S_PASS:
            begin
                cmd.out_en  = 1'b1;
                cmd.out_sel = gblur_pkg::OUT_PASS;
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end
            S_TAPS:
            begin
                // Read tap step, address tap step+1, accumulate tap step-1.
                cmd.rd_en    = (step_reg <= gblur_pkg::TAP_LAST);
                cmd.addr_en  = (step_reg < gblur_pkg::TAP_LAST);
                cmd.addr_tap = gblur_pkg::tap_t'(step_reg + 1'b1);
                cmd.mac_en   = (step_reg != gblur_pkg::TAP_FIRST);
                cmd.mac_tap  = gblur_pkg::tap_t'(step_reg - 1'b1);
                if (step_reg == gblur_pkg::TAP_DRAIN)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    step_next = gblur_pkg::tap_t'(step_reg + 1'b1);
                end
            end
            S_FIN:
            begin
                cmd.out_en  = 1'b1;
                cmd.out_sel = gblur_pkg::OUT_FILT;
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= gblur_pkg::TAP_FIRST;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

`default_nettype wire

// ----- design/gaussian_blur_3x3.sv -----
// Top level: 3x3 smoothing filter over a frame held in a single-port pixel memory.
// Each item passes the check state; an out-of-range item ends there, a load adds a write,
// a border query a read and a pass, and an interior query the tap steps and a final output.
// A new item is taken only when the last is done, in the cycle that done is shown; an
// interior query is paced by nine reads through the one memory port.
// The receiver cannot stall: each result shows for one cycle with done high.
// rst_n resets the controller and loads the kernel registers with their defaults; frame memory holds no reset value.
`default_nettype none

module gaussian_blur_3x3 #(
    parameter int WIDTH  = 800,
    parameter int HEIGHT = 600
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              mode,
    input  wire logic [gblur_pkg::COORD_W-1:0]     col,
    input  wire logic [gblur_pkg::COORD_W-1:0]     row,
    input  wire logic [gblur_pkg::PIX_W-1:0]       pixel_in,
    output logic                                   done,
    output logic [gblur_pkg::PIX_W-1:0]            pixel_out,
    output logic                                   saturated,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [gblur_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [gblur_pkg::KROW_W-1:0]      cfg_data
);

    gblur_pkg::cmd_t     cmd;
    gblur_pkg::status_t  status;

    // Register writes are always accepted and never stall.
    assign cfg_ready = 1'b1;

    gblur_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    gblur_dp #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .mode      (mode),
        .col       (col),
        .row       (row),
        .pixel_in  (pixel_in),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .pixel_out (pixel_out),
        .saturated (saturated)
    );

endmodule

`default_nettype wire

// ----- design/gblur_chk.sv -----
// Port-level checker for the smoothing filter block, bound to the top level.
`default_nettype none

module gblur_chk (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             start,
    input wire logic                             busy,
    input wire logic                             done,
    input wire logic [gblur_pkg::PIX_W-1:0]      pixel_out,
    input wire logic                             saturated
);

    // A result ends the item: the block is free while done shows.
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done asserted while busy");

    // An accepted transfer always occupies the block in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    // No result can come in the cycle right after acceptance.
    a_accept_no_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !done)
        else $error("result too early after accept");

    // Each result strobe lasts a single cycle.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // A clamped result is full scale.
    a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
        (done && saturated) |-> (pixel_out == 8'hFF))
        else $error("saturated result is not full scale");

endmodule

bind gaussian_blur_3x3 gblur_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .pixel_out (pixel_out),
    .saturated (saturated)
);

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the 3x3 smoothing filter with its pixel store.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gblur_pkg::*;

    localparam int IMG_W = 800;
    localparam int IMG_H = 600;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;
    // index 3 maps to no register
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    typedef struct {
        logic               m;
        logic [COORD_W-1:0] c;
        logic [COORD_W-1:0] r;
        logic [PIX_W-1:0]   p;
        bit                 drain;
    } pixel_cmd_t;

    typedef struct {
        logic [PIX_W-1:0] pix;
        logic             sat;
    } blur_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic                mode = MODE_LOAD;
    logic [COORD_W-1:0]  col = '0;
    logic [COORD_W-1:0]  row = '0;
    logic [PIX_W-1:0]    pixel_in = '0;
    logic                done;
    logic [PIX_W-1:0]    pixel_out;
    logic                saturated;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [KROW_W-1:0]   cfg_data = '0;

    pixel_cmd_t          pending_cmds[$];
    blur_result_t        expected_pixels[$];
    logic [PIX_W-1:0]    frame_img [IMG_W*IMG_H];
    bit                  planned_px [IMG_W*IMG_H];
    logic [KROW_W-1:0]   kernel_rows [3];
    bit                  item_taken = 1'b0;
    int                  burst_left = 1;
    int                  gap_left = 0;
    int                  idle_cycles = 0;
    int                  errors = 0;

    gaussian_blur_3x3 #(.WIDTH(IMG_W), .HEIGHT(IMG_H)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .mode      (mode),
        .col       (col),
        .row       (row),
        .pixel_in  (pixel_in),
        .done      (done),
        .pixel_out (pixel_out),
        .saturated (saturated),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic bit in_frame(int c, int r);
        return c < IMG_W && r < IMG_H;
    endfunction

    function automatic bit is_border(int c, int r);
        return c == 0 || r == 0 || c >= IMG_W - 1 || r >= IMG_H - 1;
    endfunction

    // Apply one item to the frame copy and return the result it should produce.
    function automatic blur_result_t blur_predict(logic m, logic [COORD_W-1:0] c,
                                                  logic [COORD_W-1:0] r, logic [PIX_W-1:0] p);
        blur_result_t res;
        logic [31:0]  acc;
        logic [31:0]  rounded;
        int           ci;
        int           ri;
        int           i;
        int           k;
        res.pix = '0;
        res.sat = 1'b0;
        ci = int'(c);
        ri = int'(r);
        acc = '0;
        if (in_frame(ci, ri)) begin
            if (m == MODE_LOAD) begin
                frame_img[ri*IMG_W + ci] = p;
            end
            else if (is_border(ci, ri)) begin
                res.pix = frame_img[ri*IMG_W + ci];
            end
            else begin
                for (i = 0; i < 3; i++)
                    for (k = 0; k < 3; k++)
                        acc += 32'(frame_img[(ri-1+i)*IMG_W + ci-1+k])
                               * 32'(kernel_rows[i][COEF_W*k +: COEF_W]);
                rounded = (acc + 32'h8000) >> FRAC_W;
                if (rounded > 32'd255) begin
                    res.pix = 8'hFF;
                    res.sat = 1'b1;
                end
                else begin
                    res.pix = rounded[PIX_W-1:0];
                end
            end
        end
        return res;
    endfunction

    function automatic logic [PIX_W-1:0] rand_pixel();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick < 2)
            return 8'hFF;
        else if (pick == 2)
            return 8'h00;
        return PIX_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [KROW_W-1:0] rand_krow();
        logic [63:0] v;
        v = {$urandom(), $urandom()};
        return v[KROW_W-1:0];
    endfunction

    function automatic void push_item(logic m, int c, int r, logic [PIX_W-1:0] p, bit drain);
        pixel_cmd_t it;
        it.m = m;
        it.c = c[COORD_W-1:0];
        it.r = r[COORD_W-1:0];
        it.p = p;
        it.drain = drain;
        pending_cmds.push_back(it);
        if (m == MODE_LOAD && in_frame(c, r))
            planned_px[r*IMG_W + c] = 1'b1;
    endfunction

    // Load whatever the query would read that is not written yet, then query.
    function automatic void push_query_ready(int c, int r, bit drain);
        int x0, x1, y0, y1, x, y;
        bit first;
        first = drain;
        if (in_frame(c, r)) begin
            if (is_border(c, r)) begin
                x0 = c; x1 = c; y0 = r; y1 = r;
            end
            else begin
                x0 = c - 1; x1 = c + 1; y0 = r - 1; y1 = r + 1;
            end
            for (y = y0; y <= y1; y++)
                for (x = x0; x <= x1; x++)
                    if (!planned_px[y*IMG_W + x]) begin
                        push_item(MODE_LOAD, x, y, rand_pixel(), first);
                        first = 1'b0;
                    end
        end
        push_item(MODE_QUERY, c, r, PIX_W'($urandom_range(0, 255)), first);
    endfunction

    function automatic void random_phase(int n);
        int ox[4], oy[4];
        int i, k, c, r, kind;
        bit drain;
        ox[0] = 0;         oy[0] = 0;
        ox[1] = IMG_W - 4; oy[1] = IMG_H - 4;
        ox[2] = $urandom_range(0, 1) ? 0 : IMG_W - 4;
        oy[2] = $urandom_range(0, IMG_H - 4);
        ox[3] = $urandom_range(1, IMG_W - 5);
        oy[3] = $urandom_range(1, IMG_H - 5);
        for (i = 0; i < n; i++) begin
            k = $urandom_range(0, 3);
            c = ox[k] + $urandom_range(0, 3);
            r = oy[k] + $urandom_range(0, 3);
            kind = $urandom_range(0, 99);
            drain = (i == 0) || ($urandom_range(0, 39) == 0);
            if (kind < 35) begin
                push_item(MODE_LOAD, c, r, rand_pixel(), drain);
            end
            else if (kind < 85) begin
                push_query_ready(c, r, drain);
            end
            else if (kind < 95) begin
                if ($urandom_range(0, 1)) begin
                    c = $urandom_range(IMG_W, 1023);
                    r = $urandom_range(0, 1023);
                end
                else begin
                    c = $urandom_range(0, 1023);
                    r = $urandom_range(IMG_H, 1023);
                end
                push_item(kind < 90 ? MODE_QUERY : MODE_LOAD, c, r,
                          PIX_W'($urandom_range(0, 255)), drain);
            end
            else begin
                push_item(MODE_LOAD, $urandom_range(0, IMG_W - 1),
                          $urandom_range(0, IMG_H - 1), rand_pixel(), drain);
            end
        end
    endfunction

    // Hold until the driver has run dry and every result is back.
    task automatic wait_idle();
        while (pending_cmds.size() != 0 || start || expected_pixels.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Call on a falling edge; returns on the falling edge after the transfer.
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [KROW_W-1:0] data, bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_KROW_TOP:    kernel_rows[0] = data;
            REG_KROW_MIDDLE: kernel_rows[1] = data;
            REG_KROW_BOTTOM: kernel_rows[2] = data;
            default: ;
        endcase
        @(negedge clk);
        if (last)
            cfg_valid <= 1'b0;
    endtask

    // Driver: present queued items in bursts, change inputs on the falling edge.
    always @(negedge clk) begin
        pixel_cmd_t it;
        if (!rst_n) begin
            start <= 1'b0;
        end
        else if (!start || item_taken) begin
            if (gap_left != 0) begin
                gap_left--;
                start <= 1'b0;
            end
            else if (pending_cmds.size() == 0
                     || (pending_cmds[0].drain && expected_pixels.size() != 0)) begin
                start <= 1'b0;
            end
            else begin
                it = pending_cmds.pop_front();
                start    <= 1'b1;
                mode     <= it.m;
                col      <= it.c;
                row      <= it.r;
                pixel_in <= it.p;
                if (burst_left > 1) begin
                    burst_left--;
                end
                else if ($urandom_range(0, 3) == 0) begin
                    burst_left = 60;
                    gap_left = 0;
                end
                else begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = $urandom_range(1, 10);
                end
            end
        end
    end

    // Monitor: predict on each item transfer, check each result, watch for a hang.
    always @(posedge clk) begin
        blur_result_t want;
        if (!rst_n) begin
            item_taken = 1'b0;
            idle_cycles = 0;
        end
        else begin
            if (done) begin
                if (expected_pixels.size() == 0) begin
                    $display("%0t: unexpected result pixel_out=%0d saturated=%0d",
                             $time, pixel_out, saturated);
                    errors++;
                end
                else begin
                    want = expected_pixels.pop_front();
                    if (pixel_out !== want.pix) begin
                        $display("%0t: pixel_out expected %0d got %0d",
                                 $time, want.pix, pixel_out);
                        errors++;
                    end
                    if (saturated !== want.sat) begin
                        $display("%0t: saturated expected %0d got %0d",
                                 $time, want.sat, saturated);
                        errors++;
                    end
                end
            end
            item_taken = start && !busy;
            if (item_taken)
                expected_pixels.push_back(blur_predict(mode, col, row, pixel_in));
            if (item_taken || done || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        kernel_rows[0] = KROW_TOP_RST;
        kernel_rows[1] = KROW_MIDDLE_RST;
        kernel_rows[2] = KROW_BOTTOM_RST;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: corner block at full scale, borders, far corner, out of frame.
        for (int y = 0; y < 3; y++)
            for (int x = 0; x < 3; x++)
                push_item(MODE_LOAD, x, y, 8'hFF, 1'b0);
        push_item(MODE_QUERY, 1, 1, 8'h5A, 1'b0);
        push_item(MODE_QUERY, 0, 0, 8'h00, 1'b0);
        push_item(MODE_QUERY, 2, 0, 8'hFF, 1'b0);
        push_item(MODE_QUERY, 0, 2, 8'h00, 1'b0);
        push_item(MODE_LOAD, 1, 1, 8'h00, 1'b0);
        push_item(MODE_QUERY, 1, 1, 8'h00, 1'b1);
        push_item(MODE_LOAD, IMG_W - 1, IMG_H - 1, 8'hA5, 1'b0);
        push_item(MODE_QUERY, IMG_W - 1, IMG_H - 1, 8'h00, 1'b0);
        push_item(MODE_LOAD, 1023, 1023, 8'hFF, 1'b0);
        push_item(MODE_QUERY, 1023, 1023, 8'hFF, 1'b0);
        push_item(MODE_QUERY, IMG_W, 17, 8'h00, 1'b0);
        push_item(MODE_LOAD, 3, IMG_H, 8'h3C, 1'b0);
        push_item(MODE_QUERY, 3, IMG_H, 8'h00, 1'b0);
        wait_idle();

        cfg_write(REG_KROW_TOP, rand_krow(), 1'b0);
        cfg_write(REG_KROW_MIDDLE, rand_krow(), 1'b0);
        cfg_write(REG_KROW_BOTTOM, rand_krow(), 1'b0);
        cfg_write(REG_UNMAPPED, rand_krow(), 1'b1);
        random_phase(80);
        wait_idle();

        // Full-scale weights: most interior queries clamp.
        cfg_write(REG_KROW_TOP, '1, 1'b0);
        cfg_write(REG_KROW_MIDDLE, '1, 1'b0);
        cfg_write(REG_KROW_BOTTOM, '1, 1'b1);
        random_phase(80);
        wait_idle();

        cfg_write(REG_KROW_TOP, '0, 1'b0);
        cfg_write(REG_KROW_MIDDLE, '0, 1'b0);
        cfg_write(REG_KROW_BOTTOM, '0, 1'b0);
        cfg_write(REG_UNMAPPED, '1, 1'b1);
        random_phase(80);
        wait_idle();

        cfg_write(REG_KROW_TOP, 48'h0000_0000_FFFF, 1'b0);
        cfg_write(REG_KROW_MIDDLE, 48'h0000_8000_0000, 1'b0);
        cfg_write(REG_KROW_BOTTOM, rand_krow(), 1'b1);
        random_phase(80);
        wait_idle();
        repeat (30) @(negedge clk);

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
design/gblur_pkg.sv
design/gblur_dp.sv
design/gblur_ctrl.sv
design/gaussian_blur_3x3.sv
design/gblur_chk.sv
tb/tb.sv
